/* rtl/json_string_unescape_utf8_top_assert.svh */
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet while rst is high.
`define JSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet while rst is high.
`define JSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/jsu_pkg.sv */
package jsu_pkg;

  // Results caused by one input byte: up to four content bytes and a status.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      nbytes;
    logic [1:0]      status;
  } res_t;

  localparam logic [1:0] ST_CONT  = 2'd0;
  localparam logic [1:0] ST_CLOSE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

endpackage

/* rtl/jsu_decode.sv */
module jsu_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          start_req,
  input  logic          text_end,
  output jsu_pkg::res_t res,
  output logic          emit
);
  import jsu_pkg::*;

  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_STR     = 3'd1;
  localparam logic [2:0] M_ESC     = 3'd2;
  localparam logic [2:0] M_HEX     = 3'd3;
  localparam logic [2:0] M_HELD    = 3'd4;
  localparam logic [2:0] M_HELD_BS = 3'd5;
  localparam logic [2:0] M_LOW     = 3'd6;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_U     = 8'h75;

  logic [2:0]  mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_acc, code_acc_next;
  logic [9:0]  high_held, high_held_next;

  logic [3:0]  hex_v;
  logic        hex_ok;
  logic [15:0] acc_shift;
  logic [7:0]  esc_byte;
  logic        esc_ok;
  logic [20:0] pair_cp;

  function automatic res_t utf8(input logic [20:0] cp);
    res_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.data[0] = cp[7:0];
      r.nbytes  = 3'd1;
    end else if (cp < 21'h800) begin
      r.data[0] = 8'hC0 | {3'b000, cp[10:6]};
      r.data[1] = 8'h80 | {2'b00, cp[5:0]};
      r.nbytes  = 3'd2;
    end else if (cp < 21'h10000) begin
      r.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
      r.data[1] = 8'h80 | {2'b00, cp[11:6]};
      r.data[2] = 8'h80 | {2'b00, cp[5:0]};
      r.nbytes  = 3'd3;
    end else begin
      r.data[0] = 8'hF0 | {5'b00000, cp[20:18]};
      r.data[1] = 8'h80 | {2'b00, cp[17:12]};
      r.data[2] = 8'h80 | {2'b00, cp[11:6]};
      r.data[3] = 8'h80 | {2'b00, cp[5:0]};
      r.nbytes  = 3'd4;
    end
    return r;
  endfunction

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_v = in_byte[3:0];
    end else if ((in_byte >= 8'h61 && in_byte <= 8'h66) ||
                 (in_byte >= 8'h41 && in_byte <= 8'h46)) begin
      hex_v = in_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_shift = {code_acc[11:0], hex_v};
  assign pair_cp   = 21'h10000 + {1'b0, high_held, 10'b0} + {5'b0, acc_shift} - 21'h0DC00;

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    case (in_byte)
      8'h22, 8'h5C, 8'h2F: esc_byte = in_byte;
      8'h62:               esc_byte = 8'h08;
      8'h66:               esc_byte = 8'h0C;
      8'h6E:               esc_byte = 8'h0A;
      8'h72:               esc_byte = 8'h0D;
      8'h74:               esc_byte = 8'h09;
      default:             esc_ok   = 1'b0;
    endcase
  end

  always_comb begin
    logic run_str;
    logic run_esc;
    logic pre;
    logic sput;
    logic [7:0] sb;
    logic fail;
    logic close;
    res_t held_r;

    run_str = 1'b0;
    run_esc = 1'b0;
    pre     = 1'b0;
    sput    = 1'b0;
    sb      = in_byte;
    fail    = 1'b0;
    close   = 1'b0;
    held_r  = utf8({5'b0, 6'b110110, high_held});
    res     = '0;

    mode_next      = mode;
    hex_count_next = hex_count;
    code_acc_next  = code_acc;
    high_held_next = high_held;

    if (start_req) begin
      hex_count_next = '0;
      code_acc_next  = '0;
      high_held_next = '0;
      mode_next      = M_STR;
      fail           = (in_byte != CH_QUOTE);
    end else begin
      case (mode)
        M_STR: run_str = 1'b1;
        M_ESC: run_esc = 1'b1;
        M_HEX, M_LOW: begin
          if (!hex_ok) begin
            fail = 1'b1;
          end else begin
            code_acc_next = acc_shift;
            if (hex_count == 2'd3) begin
              hex_count_next = '0;
              if (mode == M_LOW) begin
                res       = utf8(pair_cp);
                mode_next = M_STR;
              end else if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
                high_held_next = acc_shift[9:0];
                mode_next      = M_HELD;
              end else begin
                res       = utf8({5'b0, acc_shift});
                mode_next = M_STR;
              end
            end else begin
              hex_count_next = hex_count + 2'd1;
            end
          end
        end
        M_HELD: begin
          if (in_byte == CH_BSL) begin
            mode_next = M_HELD_BS;
          end else begin
            pre     = 1'b1;
            run_str = 1'b1;
          end
        end
        M_HELD_BS: begin
          if (in_byte == CH_U) begin
            mode_next      = M_LOW;
            hex_count_next = '0;
            code_acc_next  = '0;
          end else begin
            pre     = 1'b1;
            run_esc = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (run_str) begin
      if (in_byte == CH_QUOTE) begin
        close     = 1'b1;
        mode_next = M_IDLE;
      end else if (in_byte == CH_BSL) begin
        mode_next = M_ESC;
      end else if (in_byte < 8'h20) begin
        fail = 1'b1;
      end else begin
        sput      = 1'b1;
        mode_next = M_STR;
      end
    end

    if (run_esc) begin
      mode_next = M_STR;
      if (in_byte == CH_U) begin
        mode_next      = M_HEX;
        hex_count_next = '0;
        code_acc_next  = '0;
      end else if (esc_ok) begin
        sput = 1'b1;
        sb   = esc_byte;
      end else begin
        fail = 1'b1;
      end
    end

    // Held surrogate goes out first; the byte that displaced it follows.
    if (pre) begin
      res.data[2:0] = held_r.data[2:0];
      res.nbytes    = 3'd3;
      if (sput) begin
        res.data[3] = sb;
        res.nbytes  = 3'd4;
      end
    end else if (sput) begin
      res.data[0] = sb;
      res.nbytes  = 3'd1;
    end

    if (close) begin
      res.status = ST_CLOSE;
    end
    if (fail || (text_end && mode_next != M_IDLE && !(mode == M_IDLE && !start_req))) begin
      res.status = ST_ERROR;
      mode_next  = M_IDLE;
    end
  end

  assign emit = (res.nbytes != 3'd0) || (res.status != ST_CONT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= M_IDLE;
      hex_count <= '0;
      code_acc  <= '0;
      high_held <= '0;
    end else if (accept) begin
      mode      <= mode_next;
      hex_count <= hex_count_next;
      code_acc  <= code_acc_next;
      high_held <= high_held_next;
    end
  end

endmodule

/* rtl/jsu_serial.sv */
`include "json_string_unescape_utf8_top_assert.svh"

module jsu_serial (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  jsu_pkg::res_t res,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          byte_valid,
  output logic [1:0]    status,
  output logic          last
);
  import jsu_pkg::*;

  logic            busy;
  logic [1:0]      idx;
  logic [1:0]      cnt_m1;
  logic            has_byte;
  logic [3:0][7:0] data;
  logic [1:0]      st;
  logic            last_beat;

  assign last_beat = (idx == cnt_m1);
  assign in_ready  = !busy || (out_ready && last_beat);

  assign out_valid  = busy;
  assign out_byte   = has_byte ? data[idx] : 8'h00;
  assign byte_valid = has_byte;
  assign status     = last_beat ? st : ST_CONT;
  assign last       = last_beat;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (busy && out_ready) begin
      if (last_beat) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // Payload: hold while a run of beats drains.
  always_ff @(posedge clk) begin
    if (load) begin
      data     <= res.data;
      st       <= res.status;
      has_byte <= (res.nbytes != 3'd0);
      cnt_m1   <= (res.nbytes == 3'd0) ? 2'd0 : 2'(res.nbytes - 3'd1);
    end
  end

  `JSU_ASSERT_NOW(a_idx_range, busy, idx <= cnt_m1, "beat index past end of run")
  `JSU_ASSERT_NEXT(a_load_start, load, busy && idx == 2'd0, "new run did not start at beat 0")
  `JSU_ASSERT_NEXT(a_drain, busy && out_ready && last_beat && !load, !busy,
                   "buffer still full after final beat")
  `JSU_ASSERT_NEXT(a_advance, busy && out_ready && !last_beat && !load,
                   busy && idx == $past(idx) + 2'd1, "beat index did not advance")

endmodule

/* rtl/json_string_unescape_utf8_top.sv */
// Results of a byte are registered and appear on the master side in the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one result beat and m_tready is high;
//   a byte yielding k beats (k up to 4) holds the output buffer until all k beats have been taken.
// The output buffer takes the next byte in the cycle its final beat leaves.
// Reset (rst, synchronous, active high): decoder idle awaiting a quote, buffer empty.
module json_string_unescape_utf8_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic [0:0] s_tuser,   // [0] start_req
  input  logic       s_tlast,   // text_end
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic [2:0] m_tuser,   // [0] byte_valid, [2:1] status
  output logic       m_tlast    // last
);
  import jsu_pkg::*;

  res_t res;
  logic emit;
  logic accept;
  logic byte_valid;
  logic [1:0] status;

  assign accept = s_tvalid && s_tready;

  jsu_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .start_req (s_tuser[0]),
    .text_end  (s_tlast),
    .res       (res),
    .emit      (emit)
  );

  jsu_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .load       (accept && emit),
    .res        (res),
    .in_ready   (s_tready),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .byte_valid (byte_valid),
    .status     (status),
    .last       (m_tlast)
  );

  assign m_tuser = {status, byte_valid};

endmodule

/* sim/json_string_unescape_utf8_check.sv */
module json_string_unescape_utf8_check (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic [0:0] s_tuser,   // [0] start_req
  input  logic       s_tlast,   // text_end
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,   // [7:0] out_byte
  input  logic [2:0] m_tuser,   // [0] byte_valid, [2:1] status
  input  logic       m_tlast,
  output int         errors,
  output int         outstanding
);
  import jsu_pkg::*;

  typedef enum logic [3:0] {
    DEC_IDLE,
    DEC_STR,
    DEC_ESC,
    DEC_HEX,
    DEC_HELD,
    DEC_HELD_BS,
    DEC_LOW
  } dec_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic [1:0] status;
    logic       last;
  } out_beat_t;

  out_beat_t  decoded_q[$];

  dec_mode_t  mode_q;
  logic [1:0] digit_idx;
  logic [15:0] code_q;
  logic [15:0] high_q;

  logic [7:0] emit_q [4];
  int         emit_cnt;
  logic [1:0] step_st;

  initial begin
    errors      = 0;
    outstanding = 0;
    mode_q      = DEC_IDLE;
    digit_idx   = '0;
    code_q      = '0;
    high_q      = '0;
  end

  task automatic queue_beat(input logic [7:0] d, input logic v, input logic [1:0] s,
                            input logic l);
    out_beat_t nb;
    nb = '{d, v, s, l};
    decoded_q.insert(decoded_q.size(), nb);
  endtask

  task automatic emit_byte(input logic [7:0] b);
    if (emit_cnt < 4) begin
      emit_q[emit_cnt] = b;
      emit_cnt++;
    end
  endtask

  task automatic abort_string();
    step_st = ST_ERROR;
    mode_q  = DEC_IDLE;
  endtask

  task automatic emit_utf8(input logic [31:0] cp);
    if (cp < 32'h80) begin
      emit_byte(cp[7:0]);
    end else if (cp < 32'h800) begin
      emit_byte(8'hC0 | 8'(cp >> 6));
      emit_byte(8'h80 | {2'b00, cp[5:0]});
    end else if (cp < 32'h10000) begin
      emit_byte(8'hE0 | 8'(cp >> 12));
      emit_byte(8'h80 | {2'b00, cp[11:6]});
      emit_byte(8'h80 | {2'b00, cp[5:0]});
    end else begin
      emit_byte(8'hF0 | 8'(cp >> 18));
      emit_byte(8'h80 | {2'b00, cp[17:12]});
      emit_byte(8'h80 | {2'b00, cp[11:6]});
      emit_byte(8'h80 | {2'b00, cp[5:0]});
    end
  endtask

  function automatic int nibble_of(input logic [7:0] h);
    if (h >= "0" && h <= "9") return int'(h - "0");
    if (h >= "a" && h <= "f") return int'(h - "a") + 10;
    if (h >= "A" && h <= "F") return int'(h - "A") + 10;
    return -1;
  endfunction

  task automatic string_char(input logic [7:0] b);
    if (b == "\"") begin
      step_st = ST_CLOSE;
      mode_q  = DEC_IDLE;
    end else if (b == "\\") begin
      mode_q = DEC_ESC;
    end else if (b < 8'h20) begin
      abort_string();
    end else begin
      emit_byte(b);
    end
  endtask

  task automatic escape_char(input logic [7:0] b);
    mode_q = DEC_STR;
    case (b)
      "\"", "\\", "/": emit_byte(b);
      "b": emit_byte(8'h08);
      "f": emit_byte(8'h0C);
      "n": emit_byte(8'h0A);
      "r": emit_byte(8'h0D);
      "t": emit_byte(8'h09);
      "u": begin
        mode_q    = DEC_HEX;
        digit_idx = '0;
        code_q    = '0;
      end
      default: abort_string();
    endcase
  endtask

  task automatic take_digit(input logic [7:0] b, output bit done);
    int v;
    v    = nibble_of(b);
    done = 1'b0;
    if (v < 0) begin
      abort_string();
    end else begin
      code_q = {code_q[11:0], v[3:0]};
      if (digit_idx == 2'd3) begin
        digit_idx = '0;
        done      = 1'b1;
      end else begin
        digit_idx = digit_idx + 2'd1;
      end
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic start, input logic tend);
    bit          done;
    logic [31:0] cp;
    emit_cnt = 0;
    step_st  = ST_CONT;
    if (start) begin
      digit_idx = '0;
      code_q    = '0;
      high_q    = '0;
      if (b == "\"") mode_q = DEC_STR;
      else abort_string();
    end else begin
      case (mode_q)
        DEC_STR: string_char(b);
        DEC_ESC: escape_char(b);
        DEC_HEX: begin
          take_digit(b, done);
          if (done) begin
            if (code_q >= 16'hD800 && code_q <= 16'hDBFF) begin
              high_q = code_q;
              mode_q = DEC_HELD;
            end else begin
              emit_utf8({16'h0000, code_q});
              mode_q = DEC_STR;
            end
          end
        end
        DEC_HELD: begin
          if (b == "\\") begin
            mode_q = DEC_HELD_BS;
          end else begin
            emit_utf8({16'h0000, high_q});
            mode_q = DEC_STR;
            string_char(b);
          end
        end
        DEC_HELD_BS: begin
          if (b == "u") begin
            mode_q    = DEC_LOW;
            digit_idx = '0;
            code_q    = '0;
          end else begin
            emit_utf8({16'h0000, high_q});
            escape_char(b);
          end
        end
        DEC_LOW: begin
          take_digit(b, done);
          if (done) begin
            // low half is taken as it comes, in range or not
            cp = 32'h10000 + ((32'(high_q) - 32'hD800) << 10) + (32'(code_q) - 32'hDC00);
            emit_utf8(cp);
            mode_q = DEC_STR;
          end
        end
        default: begin
          // idle: drop the byte, text_end included
          mode_q = DEC_IDLE;
          return;
        end
      endcase
    end

    if (tend && mode_q != DEC_IDLE) abort_string();

    if (emit_cnt == 0) begin
      if (step_st != ST_CONT) queue_beat(8'h00, 1'b0, step_st, 1'b1);
    end else begin
      for (int k = 0; k < emit_cnt; k++) begin
        if (k == emit_cnt - 1) queue_beat(emit_q[k], 1'b1, step_st, 1'b1);
        else queue_beat(emit_q[k], 1'b1, ST_CONT, 1'b0);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    out_beat_t want;
    if (rst) begin
      mode_q    = DEC_IDLE;
      digit_idx = '0;
      code_q    = '0;
      high_q    = '0;
      decoded_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (decoded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: expected none,", $time,
                   " got data=%02h valid=%b status=%0d last=%b",
                   m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
        end else begin
          want = decoded_q.pop_front();
          if (m_tdata !== want.data || m_tuser[0] !== want.valid ||
              m_tuser[2:1] !== want.status || m_tlast !== want.last) begin
            errors++;
            $display("%0t: result mismatch:", $time,
                     " expected data=%02h valid=%b status=%0d last=%b,",
                     want.data, want.valid, want.status, want.last,
                     " got data=%02h valid=%b status=%0d last=%b",
                     m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tuser[0], s_tlast);
    end
    outstanding = decoded_q.size();
  end

endmodule

/* sim/tb_json_string_unescape_utf8_top.sv */
module tb_json_string_unescape_utf8_top;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
    logic       tend;
  } in_beat_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
  logic [0:0] s_tuser  = 1'b0;    // [0] start_req
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;            // [7:0] out_byte
  logic [2:0] m_tuser;            // [0] byte_valid, [2:1] status
  logic       m_tlast;

  int errors;
  int outstanding;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_stall_req = 0;
  int string_beats = 0;

  in_beat_t text_q[$];

  always #6 clk = ~clk;

  json_string_unescape_utf8_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  json_string_unescape_utf8_check decode_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    #2400000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rx_stall_req > 0) begin
        hold         = rx_stall_req;
        rx_stall_req = 0;
      end
      if (rst) begin
        m_tready <= 1'b0;
      end else if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic start, input logic tend);
    in_beat_t it;
    it = '{b, start, tend};
    text_q.insert(text_q.size(), it);
  endtask

  task automatic push_text(input string s, input bit start_first, input bit tend_last);
    for (int i = 0; i < s.len(); i++)
      push_beat(s[i], start_first && i == 0, tend_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return "0" + 8'(v);
    return (upper ? "A" : "a") + 8'(v) - 8'd10;
  endfunction

  task automatic push_code(input logic [15:0] code);
    push_beat("\\", 1'b0, 1'b0);
    push_beat("u", 1'b0, 1'b0);
    for (int i = 3; i >= 0; i--)
      push_beat(hex_char(code[i*4 +: 4], 1'($urandom_range(1))), 1'b0, 1'b0);
    string_beats += 6;
  endtask

  task automatic add_random_string();
    string       esc_set;
    logic [7:0]  b;
    logic [15:0] code;
    esc_set = "\"\\/bfnrt";
    push_beat("\"", 1'b1, 1'b0);
    string_beats++;
    repeat ($urandom_range(6)) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          b = 8'($urandom_range(8'h20, 8'hFF));
          if (b == "\"" || b == "\\") b = "a";
          push_beat(b, 1'b0, 1'b0);
          string_beats++;
        end
        4: begin
          push_beat("\\", 1'b0, 1'b0);
          push_beat(esc_set[$urandom_range(7)], 1'b0, 1'b0);
          string_beats += 2;
        end
        5, 6: begin
          case ($urandom_range(2))
            0: code = 16'($urandom_range(16'h007F));
            1: code = 16'($urandom_range(16'h07FF));
            default: code = 16'($urandom_range(16'hFFFF));
          endcase
          push_code(code);
        end
        7: begin
          push_code(16'($urandom_range(16'hD800, 16'hDBFF)));
          if ($urandom_range(7) == 0) push_code(16'($urandom_range(16'hFFFF)));
          else push_code(16'($urandom_range(16'hDC00, 16'hDFFF)));
        end
        8: push_code(16'($urandom_range(16'hD800, 16'hDBFF)));
        default: begin
          // corrupt: any byte at all, often breaking the string
          push_beat(8'($urandom_range(255)), 1'b0, $urandom_range(7) == 0);
          string_beats++;
        end
      endcase
    end
    // mostly close; otherwise end it on text_end or leave it open for the next start to drop
    if ($urandom_range(7) != 0) begin
      push_beat("\"", 1'b0, $urandom_range(3) == 0);
      string_beats++;
    end else if ($urandom_range(1) == 0) begin
      push_beat("z", 1'b0, 1'b1);
      string_beats++;
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 8))
      push_beat(8'($urandom_range(255)), $urandom_range(5) == 0, $urandom_range(7) == 0);
  endtask

  task automatic send_beat(input in_beat_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.b;
    s_tuser  <= it.start;
    s_tlast  <= it.tend;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic flush_text();
    while (text_q.size() > 0) send_beat(text_q.pop_front());
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  task automatic run_phase(input int tx_pct, input int rx_pct, input int beats);
    tx_idle_pct  = tx_pct;
    rx_idle_pct  = rx_pct;
    string_beats = 0;
    while (string_beats < beats) begin
      if ($urandom_range(6) == 0) add_noise();
      else add_random_string();
    end
    flush_text();
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    tx_idle_pct = 38;
    rx_idle_pct = 53;

    // idle bytes are dropped, text_end too
    push_beat(8'h41, 1'b0, 1'b0);
    push_beat(8'hFF, 1'b0, 1'b1);
    push_text("\" ~\177\200\377\"", 1'b1, 1'b0);
    push_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 1'b1, 1'b1);
    push_text("\"\\u0000\\u007F\\u00e9\\u07FF\\u0800\\u20AC\\uFFFF\"", 1'b1, 1'b0);
    push_text("\"\\uD83D\\uDE00\\uDBFF\\uDFFF\\uD800\\u0041\"", 1'b1, 1'b0);
    // held high half followed by a plain byte, an escape and a quote
    push_text("\"\\uD800x\\uDBFF\\n\\uD801\"", 1'b1, 1'b0);
    push_text("\"\\uD800\\q", 1'b1, 1'b0);
    push_text("\"\\uDBFF\001", 1'b1, 1'b0);
    push_text("abc", 1'b1, 1'b0);
    push_text("\"a\037", 1'b1, 1'b0);
    push_text("\"\\q", 1'b1, 1'b0);
    push_text("\"\\u12G", 1'b1, 1'b0);
    push_text("\"\\u12", 1'b1, 1'b1);
    push_text("\"ab", 1'b1, 1'b1);
    // restart while busy, with and without a held high half
    push_text("\"xy", 1'b1, 1'b0);
    push_text("\"\\uD800", 1'b1, 1'b0);
    push_text("\"z\"", 1'b1, 1'b0);
    push_text("\"", 1'b1, 1'b1);
    flush_text();

    run_phase(38, 53, 40);
    drain_results();

    // hold the sink off while the source keeps offering multi-byte runs
    tx_idle_pct  = 0;
    rx_stall_req = 150;
    push_beat("\"", 1'b1, 1'b0);
    repeat (4) push_code(16'h20AC);
    push_beat("\"", 1'b0, 1'b0);
    flush_text();
    drain_results();

    run_phase(53, 38, 40);
    drain_results();
    run_phase(0, 0, 40);
    drain_results();

    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
